// ----- rtl/core/sha_pkg.sv -----
// ----------------------------------------------------------------------------
// sha_pkg: shared constants, types and the rotate helper for the sha-256 hasher
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam int BlockBytes = 64;
	localparam int LengthPos  = 56;
	localparam logic [7:0] PadByte = 8'h80;

	localparam logic [31:0] InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RoundConst [64] = '{
		32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
		32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
		32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
		32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
		32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
		32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
		32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
		32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
		32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
		32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
		32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
	};

	// byte source for the buffer write port
	typedef enum logic [1:0] {
		BYTE_DATA,
		BYTE_PAD,
		BYTE_ZERO,
		BYTE_LEN
	} byte_sel_t;

	// controller to datapath
	typedef struct packed {
		logic      buf_wr;
		byte_sel_t byte_sel;
		logic      fill_clr;
		logic      len_add;
		logic      len_clr;
		logic      blk_start;
		logic      rnd_step;
		logic      hash_add;
		logic      hash_init;
	} sha_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [6:0] fill;
		logic       rnd_last;
	} sha_sts_t;

	function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
		ror32 = (v >> n) | (v << (32 - n));
	endfunction

endpackage

// ----- rtl/core/sha_datapath.sv -----
// ----------------------------------------------------------------------------
// sha_datapath: block buffer, length counter, message schedule and round unit
// ----------------------------------------------------------------------------
module sha_datapath import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  sha_cmd_t    cmd,
	input  logic [7:0]  data_byte,
	input  logic [2:0]  out_sel,
	output sha_sts_t    sts,
	output logic [31:0] hash_out
);

	// block held as sixteen big-endian words, bytes written into their lanes
	logic [31:0] buf_q [16];
	logic [6:0]  fill_q;
	logic [63:0] len_q;
	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] h_q [8];
	logic [5:0]  rnd_q;
	logic [7:0]  wr_byte;
	logic [31:0] wt, x15, x2, t1, t2, e, a, sg0, sg1;
	logic [2:0]  len_pos;

	assign len_pos = fill_q[2:0];

	always_comb begin
		case (cmd.byte_sel)
			BYTE_DATA: wr_byte = data_byte;
			BYTE_PAD:  wr_byte = PadByte;
			BYTE_ZERO: wr_byte = 8'h00;
			default:   wr_byte = len_q[8 * (7 - len_pos) +: 8];
		endcase
	end

	// schedule and round, one round per cycle
	always_comb begin
		x15 = w_q[4'(rnd_q - 6'd15)];
		x2  = w_q[4'(rnd_q - 6'd2)];
		sg0 = ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3);
		sg1 = ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10);
		if (rnd_q < 6'd16) begin
			wt = buf_q[rnd_q[3:0]];
		end else begin
			wt = w_q[rnd_q[3:0]] + sg0 + w_q[4'(rnd_q - 6'd7)] + sg1;
		end
		e  = v_q[4];
		a  = v_q[0];
		t1 = v_q[7] + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
		     + ((e & v_q[5]) ^ (~e & v_q[6])) + RoundConst[rnd_q] + wt;
		t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
		     + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk) begin
		if (cmd.buf_wr) buf_q[fill_q[5:2]][8 * (3 - fill_q[1:0]) +: 8] <= wr_byte;
		if (cmd.blk_start) begin
			for (int j = 0; j < 8; j++) v_q[j] <= h_q[j];
		end else if (cmd.rnd_step) begin
			w_q[rnd_q[3:0]] <= wt;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= e;
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= a;
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			len_q  <= '0;
			rnd_q  <= '0;
			for (int j = 0; j < 8; j++) h_q[j] <= InitHash[j];
		end else begin
			if (cmd.fill_clr)    fill_q <= '0;
			else if (cmd.buf_wr) fill_q <= fill_q + 7'd1;
			if (cmd.len_clr)      len_q <= '0;
			else if (cmd.len_add) len_q <= len_q + 64'd8;
			if (cmd.blk_start)     rnd_q <= '0;
			else if (cmd.rnd_step) rnd_q <= rnd_q + 6'd1;
			if (cmd.hash_init) begin
				for (int j = 0; j < 8; j++) h_q[j] <= InitHash[j];
			end else if (cmd.hash_add) begin
				for (int j = 0; j < 8; j++) h_q[j] <= h_q[j] + v_q[j];
			end
		end
	end

	assign sts.fill       = fill_q;
	assign sts.rnd_last   = (rnd_q == 6'd63);
	assign hash_out       = h_q[out_sel];

endmodule

// ----- rtl/core/sha_ctrl.sv -----
// ----------------------------------------------------------------------------
// sha_ctrl: sequencer for byte intake, padding, compression and digest output
// ----------------------------------------------------------------------------
module sha_ctrl import sha_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       has_byte,
	input  logic       end_of_message,
	input  sha_sts_t   sts,
	output sha_cmd_t   cmd,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] out_sel
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_START, ST_ROUND, ST_ADD, ST_PAD, ST_FILL, ST_OUT
	} state_t;

	state_t     state_q;
	logic       fin_q;     // closing in progress
	logic       pad_q;     // pad byte already written
	logic       lenblk_q;  // the block being filled carries the length
	logic [2:0] idx_q;
	logic       acc;

	assign in_ready  = (state_q == ST_IDLE);
	assign acc       = in_valid && in_ready;
	assign out_valid = (state_q == ST_OUT);
	assign out_sel   = idx_q;

	always_comb begin
		cmd = '0;
		cmd.byte_sel = BYTE_DATA;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && has_byte) begin
					cmd.buf_wr  = 1'b1;
					cmd.len_add = 1'b1;
				end
			end
			ST_START: cmd.blk_start = 1'b1;
			ST_ROUND: cmd.rnd_step  = 1'b1;
			ST_ADD: begin
				cmd.hash_add = 1'b1;
				cmd.fill_clr = 1'b1;
			end
			ST_PAD: begin
				cmd.buf_wr   = 1'b1;
				cmd.byte_sel = BYTE_PAD;
			end
			ST_FILL: begin
				cmd.buf_wr   = 1'b1;
				cmd.byte_sel = (lenblk_q && sts.fill >= 7'(LengthPos)) ? BYTE_LEN : BYTE_ZERO;
			end
			ST_OUT: begin
				if (out_ready && idx_q == 3'd7) begin
					cmd.hash_init = 1'b1;
					cmd.len_clr   = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fin_q    <= 1'b0;
			pad_q    <= 1'b0;
			lenblk_q <= 1'b0;
			idx_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						fin_q <= end_of_message;
						if (has_byte && sts.fill == 7'(BlockBytes - 1)) state_q <= ST_START;
						else if (end_of_message) state_q <= ST_PAD;
					end
				end
				ST_START: state_q <= ST_ROUND;
				ST_ROUND: if (sts.rnd_last) state_q <= ST_ADD;
				ST_ADD: begin
					if (!fin_q) state_q <= ST_IDLE;
					else if (lenblk_q) begin
						pad_q    <= 1'b0;
						lenblk_q <= 1'b0;
						state_q  <= ST_OUT;
						idx_q    <= '0;
					end else if (pad_q) begin
						// pad block without room for the length: zeros then length
						lenblk_q <= 1'b1;
						state_q  <= ST_FILL;
					end else state_q <= ST_PAD;
				end
				ST_PAD: begin
					// room for the length after the pad byte decides one or two blocks
					pad_q    <= 1'b1;
					lenblk_q <= (sts.fill < 7'(LengthPos));
					if (sts.fill == 7'(BlockBytes - 1)) state_q <= ST_START;
					else state_q <= ST_FILL;
				end
				ST_FILL: if (sts.fill == 7'(BlockBytes - 1)) state_q <= ST_START;
				ST_OUT: begin
					if (out_ready) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							state_q <= ST_IDLE;
							fin_q   <= 1'b0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/sha256_stream_hasher.sv -----
// ----------------------------------------------------------------------------
// sha256_stream_hasher: byte-stream sha-256 with padding and digest output
// ----------------------------------------------------------------------------
// a byte transaction is taken only in the idle state; the 64th byte of a block
// starts a compression (load, 64 rounds of the single round unit, hash
// add) during which no transaction is taken. a closing transaction writes the
// pad byte and zero/length bytes one per cycle up to the end of the block,
// runs one or two compressions and then offers the eight digest words h0
// first, one per output transaction, after which the hash returns to its
// initial values. no input is taken while the digest is being delivered.
module sha256_stream_hasher import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	sha_cmd_t cmd;
	sha_sts_t sts;
	logic [2:0] out_sel;

	// sequencer
	sha_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .has_byte, .end_of_message,
		.sts, .cmd, .out_valid, .out_ready, .out_sel
	);

	// buffer, schedule and round unit
	sha_datapath u_dp (
		.clk, .arst_n, .cmd, .data_byte, .out_sel, .sts, .hash_out(digest_word)
	);

	assign word_index = out_sel;
	assign last_word  = (out_sel == 3'd7);

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sha-256 byte-stream hasher
// ----------------------------------------------------------------------------
// byte transactions go in with random gaps; a software sha-256 in the bench
// pads and compresses each closed message and queues eight digest words that
// the output monitor compares against every output transaction
// ----------------------------------------------------------------------------
module tb_top;
	import sha_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// one expected output transaction
	typedef struct {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        lst;
	} digest_txn_t;

	localparam int WatchdogLimit = 20000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        has_byte;
	logic        end_of_message;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	digest_txn_t digest_q[$];
	int          mismatch_count;
	int          idle_cycles;
	bit          stall_enable;

	// bench copy of the hash state
	logic [31:0] hv [8];
	logic [7:0]  blk [64];
	int          fill;
	logic [63:0] bit_len;

	sha256_stream_hasher u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .has_byte(has_byte), .end_of_message(end_of_message),
		.out_valid(out_valid), .out_ready(out_ready),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic logic [31:0] rotr(logic [31:0] v, int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	// one 64-round compression of blk into hv
	task automatic compress_block();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
		for (int t = 0; t < 16; t++)
			w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
		for (int t = 16; t < 64; t++)
			w[t] = w[t-16] + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
				+ w[t-7] + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
		{a, b, c, d, e, f, g, h} = {hv[0], hv[1], hv[2], hv[3], hv[4], hv[5], hv[6], hv[7]};
		for (int t = 0; t < 64; t++) begin
			t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
				+ RoundConst[t] + w[t];
			t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		hv[0] += a; hv[1] += b; hv[2] += c; hv[3] += d;
		hv[4] += e; hv[5] += f; hv[6] += g; hv[7] += h;
	endtask

	task automatic restart_hash();
		for (int i = 0; i < 8; i++)
			hv[i] = InitHash[i];
		fill = 0;
		bit_len = '0;
	endtask

	// advance the bench hash by one accepted transaction, queue digest if closing
	task automatic predict_digest(logic [7:0] b, logic hb, logic eom);
		digest_txn_t txn;
		if (hb) begin
			blk[fill] = b;
			fill++;
			bit_len += 64'd8;
			if (fill == BlockBytes) begin
				compress_block();
				fill = 0;
			end
		end
		if (!eom)
			return;
		blk[fill] = PadByte;
		fill++;
		if (fill > LengthPos) begin
			while (fill < BlockBytes) begin
				blk[fill] = 8'h00;
				fill++;
			end
			compress_block();
			fill = 0;
		end
		while (fill < LengthPos) begin
			blk[fill] = 8'h00;
			fill++;
		end
		for (int i = 0; i < 8; i++)
			blk[LengthPos + i] = bit_len[8*(7-i) +: 8];
		compress_block();
		for (int k = 0; k < 8; k++) begin
			txn.word = hv[k];
			txn.idx = 3'(k);
			txn.lst = (k == 7);
			digest_q = {digest_q, txn};
		end
		restart_hash();
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		if (!stall_enable)
			return 0;
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 60);
		return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
	endfunction

	// send one transaction and update the prediction on acceptance;
	// valid stays up across back-to-back transactions
	task automatic send_item(logic [7:0] b, logic hb, logic eom);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		has_byte <= hb;
		end_of_message <= eom;
		do @(posedge clk); while (!in_ready);
		predict_digest(b, hb, eom);
	endtask

	task automatic send_message(int len, bit close_with_byte);
		for (int i = 0; i < len - 1; i++)
			send_item(8'($urandom), 1'b1, 1'b0);
		if (len == 0)
			send_item(8'($urandom), 1'b0, 1'b1);
		else if (close_with_byte)
			send_item(8'($urandom), 1'b1, 1'b1);
		else begin
			send_item(8'($urandom), 1'b1, 1'b0);
			send_item(8'($urandom), 1'b0, 1'b1);
		end
	endtask

	// empty message, byte on the closing transaction, idle transactions
	task automatic test_special_items();
		send_item(8'hff, 1'b0, 1'b1);
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'hff, 1'b1, 1'b1);
		send_item(8'ha5, 1'b0, 1'b0);
		send_item(8'h5a, 1'b1, 1'b0);
		send_item(8'h3c, 1'b0, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
	endtask

	// padding boundaries: the length fits or needs a second block
	task automatic test_pad_boundaries();
		send_message(55, 1'b1);
		send_message(56, 1'b0);
		send_message(64, 1'b1);
	endtask

	// random messages, mostly short, a few across several blocks
	task automatic test_random_messages();
		int sent;
		int len;
		sent = 0;
		while (sent < 250) begin
			stall_enable = ($urandom_range(0, 3) != 0);
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(57, 140) : $urandom_range(0, 20);
			if ($urandom_range(0, 4) == 0) begin
				send_item(8'($urandom), 1'b0, 1'b0);
				sent++;
			end
			send_message(len, $urandom_range(0, 1));
			sent += len + 1;
		end
		stall_enable = 1'b1;
	endtask

	// output side: random back-pressure and field-by-field compare
	always @(posedge clk) begin
		digest_txn_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (digest_q.size() == 0) begin
					report_mismatch("unexpected digest word", digest_word, 32'h0);
				end else begin
					want = digest_q.pop_front();
					if (digest_word !== want.word)
						report_mismatch("digest_word", digest_word, want.word);
					if (word_index !== want.idx)
						report_mismatch("word_index", 32'(word_index), 32'(want.idx));
					if (last_word !== want.lst)
						report_mismatch("last_word", 32'(last_word), 32'(want.lst));
				end
			end
			out_ready <= (gap_len() == 0);
		end
	end

	// watchdog: cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		has_byte = 1'b0;
		end_of_message = 1'b0;
		out_ready = 1'b0;
		mismatch_count = 0;
		idle_cycles = 0;
		stall_enable = 1'b1;
		restart_hash();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_items();
		test_pad_boundaries();
		test_random_messages();
		in_valid <= 1'b0;
		while (digest_q.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
